// ===== hw/rtl/wkts_pkg.sv =====
package wkts_pkg;

  localparam int KwCount = 58;
  localparam int WinLen = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

  function automatic logic [87:0] kw_text(input logic [5:0] k);
    logic [87:0] t;
    t = '0;
    case (k)
      6'd0: t[31:0] = "moon";
      6'd1: t[31:0] = "pump";
      6'd2: t[31:0] = "bull";
      6'd3: t[55:0] = "bullish";
      6'd4: t[23:0] = "buy";
      6'd5: t[31:0] = "long";
      6'd6: t[47:0] = "rocket";
      6'd7: t[23:0] = "ath";
      6'd8: t[63:0] = "breakout";
      6'd9: t[39:0] = "surge";
      6'd10: t[39:0] = "rally";
      6'd11: t[39:0] = "green";
      6'd12: t[47:0] = "higher";
      6'd13: t[15:0] = "up";
      6'd14: t[31:0] = "gain";
      6'd15: t[47:0] = "profit";
      6'd16: t[47:0] = "launch";
      6'd17: t[55:0] = "massive";
      6'd18: t[31:0] = "boom";
      6'd19: t[31:0] = "doge";
      6'd20: t[55:0] = "bitcoin";
      6'd21: t[47:0] = "crypto";
      6'd22: t[63:0] = "adoption";
      6'd23: t[55:0] = "bullrun";
      6'd24: t[39:0] = "lambo";
      6'd25: t[39:0] = "wagmi";
      6'd26: t[31:0] = "hodl";
      6'd27: t[55:0] = "diamond";
      6'd28: t[79:0] = "accumulate";
      6'd29: t[55:0] = "loading";
      6'd30: t[87:0] = "undervalued";
      6'd31: t[39:0] = "crash";
      6'd32: t[31:0] = "dump";
      6'd33: t[31:0] = "bear";
      6'd34: t[55:0] = "bearish";
      6'd35: t[31:0] = "sell";
      6'd36: t[39:0] = "short";
      6'd37: t[31:0] = "rekt";
      6'd38: t[31:0] = "scam";
      6'd39: t[23:0] = "rug";
      6'd40: t[31:0] = "fear";
      6'd41: t[39:0] = "panic";
      6'd42: t[23:0] = "red";
      6'd43: t[39:0] = "lower";
      6'd44: t[31:0] = "down";
      6'd45: t[31:0] = "loss";
      6'd46: t[31:0] = "dead";
      6'd47: t[47:0] = "bubble";
      6'd48: t[39:0] = "fraud";
      6'd49: t[23:0] = "ban";
      6'd50: t[23:0] = "sec";
      6'd51: t[55:0] = "warning";
      6'd52: t[63:0] = "collapse";
      6'd53: t[63:0] = "liquidat";
      6'd54: t[31:0] = "ngmi";
      6'd55: t[79:0] = "overvalued";
      6'd56: t[23:0] = "top";
      6'd57: t[31:0] = "exit";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [5:0] k);
    logic [3:0] n;
    case (k)
      6'd13: n = 4'd2;
      6'd4, 6'd7, 6'd39, 6'd42, 6'd49, 6'd50, 6'd56: n = 4'd3;
      6'd9, 6'd10, 6'd11, 6'd24, 6'd25, 6'd31, 6'd36, 6'd41, 6'd43, 6'd48: n = 4'd5;
      6'd6, 6'd12, 6'd15, 6'd16, 6'd21, 6'd47: n = 4'd6;
      6'd3, 6'd17, 6'd20, 6'd23, 6'd27, 6'd29, 6'd34, 6'd51: n = 4'd7;
      6'd8, 6'd22, 6'd52, 6'd53: n = 4'd8;
      6'd28, 6'd55: n = 4'd10;
      6'd30: n = 4'd11;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic signed [4:0] kw_weight(input logic [5:0] k);
    logic signed [4:0] w;
    case (k)
      6'd0, 6'd7, 6'd31, 6'd38, 6'd52: w = (k < 6'd31) ? 5'sd8 : -5'sd8;
      6'd1, 6'd2, 6'd6, 6'd8, 6'd10, 6'd25: w = 5'sd7;
      6'd32, 6'd33, 6'd37, 6'd48, 6'd53, 6'd54: w = -5'sd7;
      6'd3, 6'd23: w = 5'sd9;
      6'd34, 6'd39: w = -5'sd9;
      6'd4, 6'd5, 6'd14, 6'd15, 6'd16, 6'd22, 6'd26, 6'd27, 6'd29: w = 5'sd5;
      6'd35, 6'd36, 6'd40, 6'd45, 6'd47, 6'd51: w = -5'sd5;
      6'd9, 6'd18, 6'd24, 6'd28, 6'd30: w = 5'sd6;
      6'd41, 6'd46, 6'd49, 6'd55: w = -5'sd6;
      6'd11, 6'd12, 6'd17: w = 5'sd4;
      6'd42, 6'd43, 6'd50, 6'd57: w = -5'sd4;
      6'd13, 6'd19: w = 5'sd3;
      6'd44, 6'd56: w = -5'sd3;
      6'd20, 6'd21: w = 5'sd1;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/wkts_div.sv =====
module wkts_div (
  input  logic clk,
  input  logic rst,
  input  wkts_pkg::div_ctrl_t ctrl_in,
  input  logic signed [9:0] sum,
  input  logic [5:0] hits,
  output logic busy,
  output logic done,
  output logic signed [15:0] quot
);
  import wkts_pkg::*;

  logic [24:0] rem;
  logic [24:0] num;
  logic [9:0] den;
  logic [4:0] cnt;
  logic neg;
  logic [25:0] trial;
  logic [24:0] q;

  assign trial = {rem[23:0], num[24]} - {16'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl_in.start) begin
        busy <= 1'b1;
        cnt <= 5'd25;
        rem <= '0;
        neg <= sum[9];
        num <= {(sum[9] ? 10'(-sum) : 10'(sum)), 15'd0};
        den <= {1'b0, hits, 3'd0} + {3'd0, hits, 1'b0};
        q <= '0;
      end else if (busy) begin
        if (!trial[25]) rem <= trial[24:0];
        else rem <= {rem[23:0], num[24]};
        num <= {num[23:0], 1'b0};
        q <= {q[23:0], !trial[25]};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) quot = (q > 25'd32768) ? -16'sd32768 : 16'(-q);
    else quot = (q > 25'd32767) ? 16'sd32767 : 16'(q);
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) ctrl_in.start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without work");
endmodule

// ===== hw/rtl/weighted_keyword_text_scorer.sv =====
// Keyword scorer for a text streamed one byte per transaction on the slave side.
// s_tdata holds text_byte; s_tlast marks the final byte of a text.
// Each byte is folded to lower case and the last eleven bytes are compared
// against 58 keywords, one keyword per cycle through a shared comparator,
// so a byte takes one load step and 58 compare steps; a zero byte ends
// matching and later bytes of that text are taken without compare steps.
// On the final byte the score is divided by a 25-step restoring divider,
// which is skipped when no keyword was found, and one result
// transaction is offered on the master side: m_tdata holds score_q15,
// weight_sum and hit_count.
// s_tready is high only while the block is idle. A stalled receiver holds the
// result in the output register and the block accepts nothing meanwhile.
// Reset clears the window, marks, sums and the output valid flag; the state
// also clears after each result is sent.
module weighted_keyword_text_scorer (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [31:0] m_tdata   // [15:0] score_q15, [24:16] weight_sum, [30:25] hit_count
);
  import wkts_pkg::*;

  state_t state, state_next;
  logic [87:0] win;
  logic [57:0] marks;
  logic signed [9:0] rsum;
  logic [5:0] rhits;
  logic ended, last;
  logic [5:0] k;
  div_ctrl_t dctl;
  logic dbusy, ddone;
  logic signed [15:0] dq;
  logic [7:0] fold;
  logic [87:0] mask, kt;
  logic hit;

  assign fold = (s_tdata >= "A" && s_tdata <= "Z") ? s_tdata + 8'd32 : s_tdata;
  assign kt = kw_text(k);
  assign mask = ~(88'hFF_FFFF_FFFF_FFFF_FFFF_FFFF << {kw_len(k), 3'd0});
  assign hit = ((win & mask) == kt) && !marks[k];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = (s_tdata == 8'd0 || ended) ?
          (s_tlast ? ST_DIV_START : ST_IDLE) : ST_SCAN;
      ST_SCAN: if (k == 6'(KwCount - 1)) state_next = last ? ST_DIV_START : ST_IDLE;
      ST_DIV_START: state_next = (rhits == 6'd0) ? ST_OUT : ST_DIV;
      ST_DIV: if (ddone) state_next = ST_OUT;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
    dctl.start = (state == ST_DIV_START) && (rhits != 6'd0);
    dctl.busy = dbusy;
    dctl.done = ddone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      win <= '0;
      marks <= '0;
      rsum <= '0;
      rhits <= '0;
      ended <= 1'b0;
      last <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (s_tvalid) begin
          last <= s_tlast;
          k <= '0;
          if (s_tdata == 8'd0) ended <= 1'b1;
          if (s_tdata != 8'd0 && !ended) win <= {win[79:0], fold};
        end
        ST_SCAN: begin
          if (hit) begin
            marks[k] <= 1'b1;
            rsum <= rsum + 10'(kw_weight(k));
            rhits <= rhits + 6'd1;
          end
          k <= k + 6'd1;
        end
        ST_DIV_START: if (rhits == 6'd0) m_tdata <= '0;
        ST_DIV: if (ddone) m_tdata <= {1'b0, rhits, rsum[8:0], dq};
        ST_OUT: if (m_tready) begin
          win <= '0;
          marks <= '0;
          rsum <= '0;
          rhits <= '0;
          ended <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  wkts_div u_div (
    .clk(clk), .rst(rst), .ctrl_in(dctl), .sum(rsum), .hits(rhits),
    .busy(dbusy), .done(ddone), .quot(dq)
  );

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst) (state == ST_SCAN) |-> !dbusy)
    else $error("divider busy during scan");
endmodule

// ===== bench/weighted_keyword_text_scorer_tb.sv =====
`timescale 1ns / 100ps

class score_board;
  typedef struct {
    logic signed [15:0] score;
    logic signed [8:0] wsum;
    logic [5:0] hits;
  } score_t;

  string kw_s[58];
  int kw_w[58];
  byte unsigned window[10];
  bit [57:0] marks;
  int run_sum;
  int run_hits;
  bit ended;
  score_t pending[$];
  int errors;
  int results_seen;

  function new();
    kw_s = '{"moon", "pump", "bull", "bullish", "buy", "long", "rocket", "ath",
      "breakout", "surge", "rally", "green", "higher", "up", "gain", "profit",
      "launch", "massive", "boom", "doge", "bitcoin", "crypto", "adoption",
      "bullrun", "lambo", "wagmi", "hodl", "diamond", "accumulate", "loading",
      "undervalued", "crash", "dump", "bear", "bearish", "sell", "short", "rekt",
      "scam", "rug", "fear", "panic", "red", "lower", "down", "loss", "dead",
      "bubble", "fraud", "ban", "sec", "warning", "collapse", "liquidat", "ngmi",
      "overvalued", "top", "exit"};
    kw_w = '{8, 7, 7, 9, 5, 5, 7, 8, 7, 6, 7, 4, 4, 3, 5, 5, 5, 4, 6, 3, 1, 1, 5,
      9, 6, 7, 5, 5, 6, 5, 6, -8, -7, -7, -9, -5, -5, -7, -8, -9, -5, -6, -4, -4,
      -3, -5, -6, -5, -7, -6, -4, -5, -8, -7, -7, -6, -3, -4};
    errors = 0;
    results_seen = 0;
    clear();
  endfunction

  function void clear();
    foreach (window[i]) window[i] = 0;
    marks = '0;
    run_sum = 0;
    run_hits = 0;
    ended = 0;
  endfunction

  function void scan(byte unsigned c);
    byte unsigned buf11[11];
    int n;
    bit hit;
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    for (int i = 0; i < 10; i++) buf11[i] = window[i];
    buf11[10] = c;
    for (int k = 0; k < 58; k++) begin
      n = kw_s[k].len();
      hit = !marks[k];
      for (int j = 0; j < n; j++)
        if (buf11[11 - n + j] != kw_s[k][j]) hit = 0;
      if (hit) begin
        marks[k] = 1;
        run_sum += kw_w[k];
        run_hits = (run_hits + 1) & 63;
      end
    end
    for (int i = 0; i < 9; i++) window[i] = window[i + 1];
    window[9] = c;
  endfunction

  function void note_input(logic [7:0] c, logic last);
    score_t r;
    int q;
    if (!ended) begin
      if (c == 0) ended = 1;
      else scan(c);
    end
    if (!last) return;
    q = 0;
    if (run_hits != 0) begin
      q = (run_sum * 32768) / (run_hits * 10);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end
    r.score = q;
    r.wsum = run_sum;
    r.hits = run_hits;
    pending.push_back(r);
    clear();
  endfunction

  function void check_result(logic [31:0] d);
    score_t e;
    results_seen++;
    if (pending.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (d[15:0] !== e.score) begin
      $error("score_q15 expected %0d actual %0d", e.score, $signed(d[15:0]));
      errors++;
    end
    if (d[24:16] !== e.wsum) begin
      $error("weight_sum expected %0d actual %0d", e.wsum, $signed(d[24:16]));
      errors++;
    end
    if (d[30:25] !== e.hits) begin
      $error("hit_count expected %0d actual %0d", e.hits, d[30:25]);
      errors++;
    end
  endfunction
endclass

module weighted_keyword_text_scorer_tb;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = 0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic quiet = 0;
  int cycles = 0;
  int texts = 0;
  score_board sb;

  localparam int CycleLimit = 1500000;

  string vocab[$] = '{"moon", "pump", "bullish", "buy", "long", "rocket", "ath",
    "breakout", "surge", "rally", "green", "higher", "up", "gain", "profit",
    "launch", "massive", "boom", "doge", "bitcoin", "crypto", "adoption",
    "bullrun", "lambo", "wagmi", "hodl", "diamond", "accumulate", "loading",
    "undervalued", "crash", "dump", "bearish", "sell", "short", "rekt", "scam",
    "rug", "fear", "panic", "red", "lower", "down", "loss", "dead", "bubble",
    "fraud", "ban", "sec", "warning", "collapse", "liquidated", "ngmi",
    "overvalued", "top", "exit", "the", "a", "market"};

  weighted_keyword_text_scorer u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("weighted_keyword_text_scorer test failed");
      $finish;
    end
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(3) != 0) m_tready <= 1;
      else begin
        gap = $urandom_range(1, 8);
        m_tready <= 0;
        repeat (gap) @(posedge clk);
        m_tready <= 1;
      end
    end
  end

  task automatic send(logic [7:0] c, logic last);
    if (!quiet && $urandom_range(7) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(c, last);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], i == s.len() - 1);
    texts++;
  endtask

  task automatic random_text(output int n);
    string s;
    string w;
    byte unsigned c;
    int words;
    s = "";
    words = $urandom_range(1, 4);
    for (int i = 0; i < words; i++) begin
      w = vocab[$urandom_range(vocab.size() - 1)];
      for (int j = 0; j < w.len(); j++)
        if ($urandom_range(3) == 0) w[j] = w[j] - 8'd32;
      s = {s, w};
      case ($urandom_range(5))
        0: s = {s, " "};
        1: begin
          c = $urandom_range(255);
          if (c == 0) c = 8'h80;
          s = {s, " "};
          s[s.len() - 1] = c;
        end
        default: ;
      endcase
    end
    n = s.len();
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(60) == 0) c = 0;
      else if ($urandom_range(20) == 0) c = $urandom_range(255);
      else c = s[i];
      send(c, i == s.len() - 1);
    end
    texts++;
  endtask

  initial begin
    int sent;
    int n;
    bit drained;
    sb = new();
    drained = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(8'hff, 1);
    send(8'h00, 1);
    send_text("BullRun");
    send_text("undervalued");
    send_text("overvalued");
    send_text("collapse");
    sent = 38;
    send(8'h7f, 0);
    send(8'h00, 0);
    send_text("moon");
    sent += 6;
    while (sent < 1150) begin
      if (sent > 1050) quiet = 1;
      if (!drained && sent > 500) begin
        drain();
        drained = 1;
      end
      random_text(n);
      sent += n;
    end
    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d texts of mixed-case keywords, noise and zero bytes.", texts);
    $display("Checked %0d results.", sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("weighted_keyword_text_scorer test passed");
    else
      $display("weighted_keyword_text_scorer test failed");
    $finish;
  end
endmodule
